FILE: rtl/core/lil_pkg.sv
// Shared types and constants for the indexed LRU list.
package lil_pkg;

   localparam int POS_W          = 10;
   localparam int CNT_W          = 11;
   localparam int OP_W           = 3;
   localparam int STAT_W         = 3;
   localparam int POOL_DEPTH_DEF = 1024;
   localparam int REQ_TDATA_W    = 16;
   localparam int RSP_TDATA_W    = 48;
   localparam int REQ_PAD_W      = REQ_TDATA_W - OP_W - POS_W;
   localparam int RSP_PAD_W      = RSP_TDATA_W - STAT_W - 3 * POS_W - CNT_W - 2;

   localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(1024);

   typedef enum logic [OP_W-1:0] {
      OP_NEW      = 3'd0,
      OP_FREE     = 3'd1,
      OP_TOUCH    = 3'd2,
      OP_POP_HEAD = 3'd3,
      OP_POP_TAIL = 3'd4,
      OP_CLEAN    = 3'd5
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK      = 3'd0,
      STAT_RANGE   = 3'd1,
      STAT_USED    = 3'd2,
      STAT_NOTUSED = 3'd3,
      STAT_EMPTY   = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_UL_L,
      S_UL_LW,
      S_UL_R,
      S_UL_RW,
      S_UL_P,
      S_LINK,
      S_LK_H,
      S_LK_P,
      S_SWEEP,
      S_DONE
   } lil_state_type;

   typedef struct packed {
      logic             used;
      logic [POS_W-1:0] prev;
      logic [POS_W-1:0] next;
   } link_word_type;

   typedef struct packed {
      logic             wr_en;
      logic [POS_W-1:0] wr_addr;
      link_word_type    wr_data;
      logic [POS_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  popped;
      logic [POS_W-1:0]  head;
      logic [POS_W-1:0]  tail;
      logic              nonempty;
      logic [CNT_W-1:0]  count;
      logic              full;
   } rsp_type;

endpackage

FILE: rtl/core/lil_link_mem.sv
// Entry memory: used mark and both links per entry, one write and one registered read.
module lil_link_mem #(
   parameter int DEPTH = lil_pkg::POOL_DEPTH_DEF
) (
   input  logic                  clock,
   input  lil_pkg::mem_req_type  mem_req,
   output lil_pkg::link_word_type rd_data_ff
);
   import lil_pkg::*;

   localparam int AW = $clog2(DEPTH);

   link_word_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[AW'(mem_req.wr_addr)] <= mem_req.wr_data;
      end
      rd_data_ff <= mem[AW'(mem_req.rd_addr)];
   end

endmodule

FILE: rtl/core/lil_seq.sv
// Operation sequencer: list ends, count, memory read-modify-write steps and result register.
module lil_seq #(
   parameter int MEM_DEPTH = lil_pkg::POOL_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [lil_pkg::OP_W-1:0]    req_op,
   input  logic [lil_pkg::POS_W-1:0]   req_pos,
   input  logic [lil_pkg::CNT_W-1:0]   eff_limit,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output lil_pkg::rsp_type            rsp_data,
   output lil_pkg::mem_req_type        mem_req,
   input  lil_pkg::link_word_type      mem_rd
);
   import lil_pkg::*;

   localparam logic [POS_W-1:0] SWEEP_LAST = POS_W'(MEM_DEPTH - 1);

   lil_state_type    state_ff, state_in;
   logic [POS_W-1:0] head_ff, head_in;
   logic [POS_W-1:0] tail_ff, tail_in;
   logic             nonempty_ff, nonempty_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0] sweep_ff, sweep_in;
   logic             sweep_rsp_ff, sweep_rsp_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   op_type           op_ff, op_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] link_l_ff, link_l_in;
   logic [POS_W-1:0] link_r_ff, link_r_in;
   status_type       status_ff, status_in;
   logic [POS_W-1:0] popped_ff, popped_in;
   logic             rsp_load;
   logic             in_range;

   assign in_range   = {1'b0, pos_ff} < eff_limit;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         head_ff      <= '0;
         tail_ff      <= '0;
         nonempty_ff  <= 1'b0;
         count_ff     <= '0;
         sweep_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         nonempty_ff  <= nonempty_in;
         count_ff     <= count_in;
         sweep_ff     <= sweep_in;
         sweep_rsp_ff <= sweep_rsp_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      link_l_ff <= link_l_in;
      link_r_ff <= link_r_in;
      status_ff <= status_in;
      popped_ff <= popped_in;
      if (rsp_load) begin
         rsp_ff.status   <= status_ff;
         rsp_ff.popped   <= popped_ff;
         rsp_ff.head     <= nonempty_ff ? head_ff : '0;
         rsp_ff.tail     <= nonempty_ff ? tail_ff : '0;
         rsp_ff.nonempty <= nonempty_ff;
         rsp_ff.count    <= count_ff;
         rsp_ff.full     <= count_ff >= eff_limit;
      end
   end

   always_comb begin
      state_in         = state_ff;
      head_in          = head_ff;
      tail_in          = tail_ff;
      nonempty_in      = nonempty_ff;
      count_in         = count_ff;
      sweep_in         = sweep_ff;
      sweep_rsp_in     = sweep_rsp_ff;
      op_in            = op_ff;
      pos_in           = pos_ff;
      link_l_in        = link_l_ff;
      link_r_in        = link_r_ff;
      status_in        = status_ff;
      popped_in        = popped_ff;
      rsp_load         = 1'b0;
      req_tready       = 1'b0;
      mem_req.wr_en    = 1'b0;
      mem_req.wr_addr  = pos_ff;
      mem_req.wr_data  = '0;
      mem_req.rd_addr  = pos_ff;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            case (op_type'(req_op))
               OP_POP_HEAD: mem_req.rd_addr = head_ff;
               OP_POP_TAIL: mem_req.rd_addr = tail_ff;
               default:     mem_req.rd_addr = req_pos;
            endcase
            if (req_tvalid) begin
               op_in     = op_type'(req_op);
               pos_in    = mem_req.rd_addr;
               status_in = STAT_OK;
               popped_in = '0;
               if (op_type'(req_op) == OP_CLEAN) begin
                  state_in     = S_SWEEP;
                  sweep_in     = '0;
                  sweep_rsp_in = 1'b1;
                  head_in      = '0;
                  tail_in      = '0;
                  nonempty_in  = 1'b0;
                  count_in     = '0;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            link_l_in = mem_rd.prev;
            link_r_in = mem_rd.next;
            state_in  = S_DONE;
            case (op_ff)
               OP_NEW: begin
                  if (!in_range) status_in = STAT_RANGE;
                  else if (mem_rd.used) status_in = STAT_USED;
                  else state_in = S_LINK;
               end
               OP_FREE: begin
                  if (!in_range) status_in = STAT_RANGE;
                  else if (!mem_rd.used) status_in = STAT_NOTUSED;
                  else state_in = S_UL_L;
               end
               OP_TOUCH: begin
                  if (!in_range) status_in = STAT_RANGE;
                  else if (!mem_rd.used) status_in = STAT_NOTUSED;
                  else if (head_ff != pos_ff) state_in = S_UL_L;
               end
               OP_POP_HEAD, OP_POP_TAIL: begin
                  if (!nonempty_ff) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     popped_in = pos_ff;
                     state_in  = S_UL_L;
                  end
               end
               default: ;
            endcase
         end
         S_UL_L: begin
            if (head_ff == pos_ff) begin
               head_in  = link_r_ff;
               state_in = S_UL_R;
            end else begin
               mem_req.rd_addr = link_l_ff;
               state_in        = S_UL_LW;
            end
         end
         S_UL_LW: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = link_l_ff;
            mem_req.wr_data = '{used: mem_rd.used, prev: mem_rd.prev, next: link_r_ff};
            state_in        = S_UL_R;
         end
         S_UL_R: begin
            if (tail_ff == pos_ff) begin
               tail_in  = link_l_ff;
               state_in = S_UL_P;
            end else begin
               mem_req.rd_addr = link_r_ff;
               state_in        = S_UL_RW;
            end
         end
         S_UL_RW: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = link_r_ff;
            mem_req.wr_data = '{used: mem_rd.used, prev: link_l_ff, next: mem_rd.next};
            state_in        = S_UL_P;
         end
         S_UL_P: begin
            mem_req.wr_en = 1'b1;
            count_in      = count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               nonempty_in = 1'b0;
               head_in     = '0;
               tail_in     = '0;
            end
            state_in = (op_ff == OP_TOUCH) ? S_LINK : S_DONE;
         end
         S_LINK: begin
            if (nonempty_ff) begin
               mem_req.rd_addr = head_ff;
               state_in        = S_LK_H;
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_data = '{used: 1'b1, prev: '0, next: '0};
               head_in         = pos_ff;
               tail_in         = pos_ff;
               nonempty_in     = 1'b1;
               count_in        = count_ff + CNT_W'(1);
               state_in        = S_DONE;
            end
         end
         S_LK_H: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = head_ff;
            mem_req.wr_data = '{used: mem_rd.used, prev: pos_ff, next: mem_rd.next};
            state_in        = S_LK_P;
         end
         S_LK_P: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = '{used: 1'b1, prev: '0, next: head_ff};
            head_in         = pos_ff;
            count_in        = count_ff + CNT_W'(1);
            state_in        = S_DONE;
         end
         S_SWEEP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = sweep_ff;
            sweep_in        = sweep_ff + POS_W'(1);
            if (sweep_ff == SWEEP_LAST) begin
               state_in = sweep_rsp_ff ? S_DONE : S_IDLE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: rtl/core/indexed_lru_list.sv
// Indexed LRU list top level: ports, limit register, entry memory and sequencer.
//
// Keeps a recency order over a pool of entries as a doubly linked list.
// Request words on req_* carry an operation and a position; each request
// gives exactly one response word on rsp_* with status, popped position,
// head, tail, non-empty flag, used count and full flag after the operation.
// csr_wr_en writes the entry limit (positions at or above it are out of
// range); write it only while no request is in flight.
// Errors, touch of the head, unused codes and empty pops go from the check
// state straight to the response; the other operations step through the
// unlink and link states. One request is worked at a time; each step uses
// registered reads and single writes of the link memory. Clean clears the
// ends and count and sweeps the memory before it responds.
// Reset clears the ends and count and then sweeps the memory once, one entry
// per cycle, with req_tready low. A stalled response is held in the output
// register; the next request is still taken and waits only at its own end
// for the register to free up.
module indexed_lru_list #(
   parameter int POOL_DEPTH = lil_pkg::POOL_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // operation [2:0], position [12:3]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lil_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // status [2:0], popped_position [12:3], head_position [22:13],
   // tail_position [32:23], list_nonempty [33], used_count [44:34], is_full [45]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lil_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [lil_pkg::CNT_W-1:0]         csr_wr_data
);
   import lil_pkg::*;

   localparam int MEM_DEPTH = (POOL_DEPTH < (1 << POS_W)) ? POOL_DEPTH : (1 << POS_W);

   logic [CNT_W-1:0] entry_limit_ff;
   logic [CNT_W-1:0] eff_limit;
   mem_req_type      mem_req;
   link_word_type    mem_rd;
   rsp_type          rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         entry_limit_ff <= csr_wr_data;
      end
   end

   assign eff_limit = (32'(entry_limit_ff) < POOL_DEPTH) ? entry_limit_ff
                                                         : CNT_W'(POOL_DEPTH);

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_data.full, rsp_data.count,
                       rsp_data.nonempty, rsp_data.tail, rsp_data.head,
                       rsp_data.popped, rsp_data.status};

   lil_link_mem #(
      .DEPTH (MEM_DEPTH)
   ) u_link_mem (
      .clock      (clock),
      .mem_req    (mem_req),
      .rd_data_ff (mem_rd)
   );

   lil_seq #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tdata[OP_W-1:0]),
      .req_pos    (req_tdata[OP_W+POS_W-1:OP_W]),
      .eff_limit  (eff_limit),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data),
      .mem_req    (mem_req),
      .mem_rd     (mem_rd)
   );

endmodule

FILE: rtl/core/lil_checker.sv
// Port-level checks on the indexed LRU list, bound to the top level.
module lil_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lil_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import lil_pkg::*;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is being worked");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   a_nonempty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[33] == (rsp_tdata[44:34] != '0)))
      else $error("non-empty flag disagrees with used count");

   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[33] |-> rsp_tdata[32:13] == '0)
      else $error("head or tail set on empty list");

   a_pop_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] != STAT_OK) |-> rsp_tdata[12:3] == '0)
      else $error("popped position reported on failed operation");

endmodule

bind indexed_lru_list lil_checker u_lil_checker (.*);
